### rtl/srwc_pkg.sv
// Shared types and constants for the shadow register write cache.
// No dependencies; used by srwc_ctrl, srwc_dp and the top level.
package srwc_pkg;

    localparam int IN_DATA_W  = 64;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_USER_W = 3;

    localparam logic [2:0] CMD_WRITE  = 3'd0;
    localparam logic [2:0] CMD_UPDATE = 3'd1;
    localparam logic [2:0] CMD_WDONE  = 3'd2;
    localparam logic [2:0] CMD_RDATA  = 3'd3;
    localparam logic [2:0] CMD_CLEAR  = 3'd4;

    localparam logic [2:0] KIND_OK       = 3'd0;
    localparam logic [2:0] KIND_FAIL     = 3'd1;
    localparam logic [2:0] KIND_WRITE    = 3'd2;
    localparam logic [2:0] KIND_READ     = 3'd3;
    localparam logic [2:0] KIND_DELAY    = 3'd4;
    localparam logic [2:0] KIND_ADDR_ERR = 3'd5;

    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [7:0] ADDR_DELAY = 8'hFF;
    localparam logic [7:0] ADDR_BANK  = 8'h7F;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic lookup;
        logic execute;
    } ctrl_cmd_t;

endpackage

### rtl/srwc_ctrl.sv
// Sequencing state machine: accept, shadow lookup, execute, send.
// Depends on srwc_pkg.
module srwc_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output srwc_pkg::ctrl_cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LOOK = 4'b0010,
        ST_EXEC = 4'b0100,
        ST_SEND = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        cmd         = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                cmd.lookup = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                cmd.execute = 1'b1;
                state_next  = ST_SEND;
            end
            ST_SEND:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/srwc_dp.sv
// Datapath: captured item, pending request, bank, valid marks, shadow memory
// and result register. Depends on srwc_pkg; driven by srwc_ctrl.
module srwc_dp
#(
    parameter int REGS_PER_BANK = 127,
    parameter int NUM_BANKS     = 2
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  srwc_pkg::ctrl_cmd_t                 cmd,
    input  logic [srwc_pkg::IN_DATA_W-1:0]      in_data,
    input  logic [srwc_pkg::IN_USER_W-1:0]      in_user,
    output logic [srwc_pkg::OUT_DATA_W-1:0]     out_data,
    output logic [srwc_pkg::OUT_USER_W-1:0]     out_user
);

    localparam int DEPTH = REGS_PER_BANK * NUM_BANKS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [8:0] BANK_BASE = 9'(REGS_PER_BANK);
    localparam logic [7:0] REG_LIMIT = 8'(REGS_PER_BANK);

    // captured item
    logic [2:0]  command_reg;
    logic [7:0]  addr_reg;
    logic [15:0] val_reg;
    logic [15:0] msk_reg;
    logic        ok_reg;
    logic [15:0] rd_reg;

    // persistent state
    logic        bank_reg,   bank_next;
    logic [1:0]  op_reg,     op_next;
    logic [7:0]  preg_reg,   preg_next;
    logic [15:0] pval_reg,   pval_next;
    logic [15:0] pmask_reg,  pmask_next;
    logic [DEPTH-1:0] valid_reg;

    logic [15:0] mem [DEPTH];

    // lookup results
    logic [AW-1:0] slot_reg;
    logic          hit_reg;
    logic [15:0]   sh_reg;

    // result register
    logic [2:0]  kind_reg,  kind_next;
    logic [7:0]  oreg_reg,  oreg_next;
    logic [15:0] oval_reg,  oval_next;
    logic [15:0] delay_reg, delay_next;

    logic [7:0]    sel_reg;
    logic          sel_in_range;
    logic          bank_eff;
    logic [8:0]    slot_sum;
    logic [AW-1:0] slot;

    logic          wr_req;
    logic [7:0]    wr_addr;
    logic [15:0]   wr_val;
    logic          mem_we;
    logic          clear_all;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            command_reg <= in_user;
            addr_reg    <= in_data[7:0];
            val_reg     <= {in_data[15:8], in_data[23:16]};
            msk_reg     <= {in_data[31:24], in_data[39:32]};
            ok_reg      <= in_data[40];
            rd_reg      <= {in_data[48:41], in_data[56:49]};
        end
    end

    // slot of the addressed register in the active bank
    always_comb
    begin
        sel_reg      = ((command_reg == srwc_pkg::CMD_WDONE) ||
                        (command_reg == srwc_pkg::CMD_RDATA)) ? preg_reg : addr_reg;
        sel_in_range = sel_reg < REG_LIMIT;
        bank_eff     = (NUM_BANKS > 1) ? bank_reg : 1'b0;
        slot_sum     = bank_eff ? (BANK_BASE + {1'b0, sel_reg}) : {1'b0, sel_reg};
        slot         = sel_in_range ? slot_sum[AW-1:0] : '0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            sh_reg   <= mem[slot];
            slot_reg <= slot;
        end
        if (mem_we)
        begin
            mem[slot_reg] <= pval_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (cmd.lookup)
        begin
            hit_reg <= sel_in_range & valid_reg[slot];
        end
    end

    always_comb
    begin
        bank_next  = bank_reg;
        op_next    = op_reg;
        preg_next  = preg_reg;
        pval_next  = pval_reg;
        pmask_next = pmask_reg;
        kind_next  = srwc_pkg::KIND_FAIL;
        oreg_next  = '0;
        oval_next  = '0;
        delay_next = '0;
        wr_req     = 1'b0;
        wr_addr    = addr_reg;
        wr_val     = val_reg;
        mem_we     = 1'b0;
        clear_all  = 1'b0;

        unique case (command_reg)
            srwc_pkg::CMD_WRITE:
            begin
                priority if (addr_reg == srwc_pkg::ADDR_DELAY)
                begin
                    kind_next  = srwc_pkg::KIND_DELAY;
                    delay_next = val_reg;
                end
                else if (addr_reg == srwc_pkg::ADDR_BANK)
                begin
                    bank_next = val_reg[0];
                    op_next   = srwc_pkg::OP_WRITE;
                    preg_next = addr_reg;
                    pval_next = val_reg;
                    kind_next = srwc_pkg::KIND_WRITE;
                    oreg_next = addr_reg;
                    oval_next = val_reg;
                end
                else if (addr_reg >= REG_LIMIT)
                begin
                    kind_next = srwc_pkg::KIND_ADDR_ERR;
                end
                else
                begin
                    wr_req = 1'b1;
                end
            end
            srwc_pkg::CMD_UPDATE:
            begin
                priority if (addr_reg >= REG_LIMIT)
                begin
                    kind_next = srwc_pkg::KIND_ADDR_ERR;
                end
                else if (hit_reg)
                begin
                    wr_req = 1'b1;
                    wr_val = val_reg | (sh_reg & msk_reg);
                end
                else
                begin
                    op_next    = srwc_pkg::OP_READ;
                    preg_next  = addr_reg;
                    pval_next  = val_reg;
                    pmask_next = msk_reg;
                    kind_next  = srwc_pkg::KIND_READ;
                    oreg_next  = addr_reg;
                end
            end
            srwc_pkg::CMD_WDONE:
            begin
                if (op_reg == srwc_pkg::OP_WRITE)
                begin
                    op_next = srwc_pkg::OP_NONE;
                    if (ok_reg)
                    begin
                        mem_we    = preg_reg < REG_LIMIT;
                        kind_next = srwc_pkg::KIND_OK;
                    end
                end
            end
            srwc_pkg::CMD_RDATA:
            begin
                if (op_reg == srwc_pkg::OP_READ)
                begin
                    op_next = srwc_pkg::OP_NONE;
                    if (ok_reg && (preg_reg < REG_LIMIT))
                    begin
                        wr_req  = 1'b1;
                        wr_addr = preg_reg;
                        wr_val  = pval_reg | (rd_reg & pmask_reg);
                    end
                end
            end
            srwc_pkg::CMD_CLEAR:
            begin
                clear_all = 1'b1;
                kind_next = srwc_pkg::KIND_OK;
            end
            default:
            begin
                kind_next = srwc_pkg::KIND_FAIL;
            end
        endcase

        if (wr_req)
        begin
            if (hit_reg && (sh_reg == wr_val))
            begin
                kind_next = srwc_pkg::KIND_OK;
            end
            else
            begin
                op_next   = srwc_pkg::OP_WRITE;
                preg_next = wr_addr;
                pval_next = wr_val;
                kind_next = srwc_pkg::KIND_WRITE;
                oreg_next = wr_addr;
                oval_next = wr_val;
            end
        end

        mem_we    = mem_we & cmd.execute;
        clear_all = clear_all & cmd.execute;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg  <= 1'b0;
            op_reg    <= srwc_pkg::OP_NONE;
            preg_reg  <= '0;
            pval_reg  <= '0;
            pmask_reg <= '0;
            valid_reg <= '0;
        end
        else
        begin
            if (cmd.execute)
            begin
                bank_reg  <= bank_next;
                op_reg    <= op_next;
                preg_reg  <= preg_next;
                pval_reg  <= pval_next;
                pmask_reg <= pmask_next;
            end
            if (clear_all)
            begin
                valid_reg <= '0;
            end
            else if (mem_we)
            begin
                valid_reg[slot_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            kind_reg  <= kind_next;
            oreg_reg  <= oreg_next;
            oval_reg  <= oval_next;
            delay_reg <= delay_next;
        end
    end

    assign out_user = kind_reg;
    assign out_data = {delay_reg, oval_reg[7:0], oval_reg[15:8], oreg_reg};

endmodule

### rtl/shadow_register_write_cache_top.sv
// Top level of the shadow register write cache.
// Depends on srwc_pkg, srwc_ctrl and srwc_dp.
//
// Usage:
//   The slave side takes one command per transfer: s_tuser holds the command
//   (write, masked update, bus write done, bus read data, clear), s_tdata the
//   register address, value, mask, bus outcome and read data.
//   The master side returns exactly one result per command: m_tuser is the
//   result kind (done, failed, bus write, bus read, delay, address error),
//   m_tdata the register address, bus data and delay in milliseconds.
//   After the input transfer the command passes the lookup state (registered
//   shadow memory read) and the execute state before m_tvalid rises. One
//   command is in flight at a time; s_tready is high only when the block is
//   empty, so a new command is taken only after the previous result has been
//   transferred.
//   Reset clears the valid marks, active bank and pending request; the shadow
//   memory itself is not cleared and needs no sweep.
//   When the receiver holds m_tready low the result waits in the output
//   register and no new command is taken until it is transferred.
module shadow_register_write_cache_top
#(
    parameter int REGS_PER_BANK = 127,
    parameter int NUM_BANKS     = 2
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // reg_addr, value_high, value_low, mask_high, mask_low, bus_ok,
    // read_high, read_low, zero pad
    input  logic [srwc_pkg::IN_DATA_W-1:0]      s_tdata,
    // command
    input  logic [srwc_pkg::IN_USER_W-1:0]      s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // out_reg, out_high, out_low, delay_ms
    output logic [srwc_pkg::OUT_DATA_W-1:0]     m_tdata,
    // result_kind
    output logic [srwc_pkg::OUT_USER_W-1:0]     m_tuser
);

    srwc_pkg::ctrl_cmd_t cmd;

    srwc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd)
    );

    srwc_dp
    #(
        .REGS_PER_BANK (REGS_PER_BANK),
        .NUM_BANKS     (NUM_BANKS)
    )
    u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_data  (s_tdata),
        .in_user  (s_tuser),
        .out_data (m_tdata),
        .out_user (m_tuser)
    );

endmodule
